### sv/dasl_pkg.sv
package dasl_pkg;

    localparam int SUM_BITS  = 48;
    localparam int SHIFT_MAX = 63;
    localparam int RES_MAX   = 16;

    // Mode codes of an input item.
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic LOG_SHORT = 1'b0;
    localparam logic LOG_LONG  = 1'b1;

    // Controls for the shared rounding shifter.
    typedef struct packed {
        logic [SUM_BITS:0] x;
        logic [5:0]        s;
    } shr_req_t;

    function automatic logic [SUM_BITS:0] rshift_round(input logic [SUM_BITS:0] x,
                                                      input logic [5:0] s);
        logic [SUM_BITS+1:0] t;
        begin
            t = '0;
            if (s == 6'd0) begin
                rshift_round = x;
            end else begin
                t = {1'b0, x >> (s - 6'd1)} + {{SUM_BITS+1{1'b0}}, 1'b1};
                rshift_round = t[SUM_BITS+1:1];
            end
        end
    endfunction

endpackage

### sv/dasl_shifter.sv
module dasl_shifter #(
    parameter int ENTRY_BITS = 16
) (
    input  dasl_pkg::shr_req_t            req,
    output logic [dasl_pkg::SUM_BITS:0]   y,
    output logic                          fits
);
    import dasl_pkg::*;

    // One rounding right shift and the compare against the entry range.
    always_comb begin
        y    = rshift_round(req.x, req.s);
        fits = (y >> ENTRY_BITS) == '0;
    end
endmodule

### sv/decimating_autoscale_sample_log.sv
// Decimating auto-scaling sample log.
// Input channel s_*: mode 0 appends one count sample, mode 1 reads one entry of
// the short (which_log 0) or long (which_log 1) store at entry_index. Every
// accepted item gives exactly one result item on m_*: the value read (0 for an
// add or an index not below the length) and the state after the item.
// The block handles one item at a time around a single rounding shifter and
// one read and one write port per store, walked by a small sequencer. A read
// goes through ST_READ, a plain add through ST_APPEND or ST_GADD, and an add
// that closes a group through ST_GADD, ST_GSCALE and ST_APPEND, with a fit,
// rescale or merge between where needed; s_ready returns the cycle after the
// result is taken. Moving the short store into the long store scans it for the
// maximum, searches a fitting shift and copies it; a rescale walks the long
// store once, a pair merge walks it twice, and a fit search tries shifts up to 63.
// s_ready is low from acceptance until the result is taken, so a stalled
// receiver simply holds the block. Reset clears lengths, scale, phase, group sum
// and count and sets resolution to 1; store contents are not cleared, nor need to be.
module decimating_autoscale_sample_log #(
    parameter int SHORT_DEPTH = 40,
    parameter int LONG_DEPTH  = 240,
    parameter int ENTRY_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_sample,
    input  logic        s_which_log,
    input  logic [7:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_value,
    output logic [5:0]  m_short_count,
    output logic [7:0]  m_long_count,
    output logic [5:0]  m_scale_shift,
    output logic [4:0]  m_resolution,
    output logic        m_long_phase
);
    import dasl_pkg::*;

    localparam int SA = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int LA = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int NXFER = (SHORT_DEPTH < LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH;
    localparam int HALF = LONG_DEPTH / 2;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_READ   = 14'b00000000000010,
        ST_TMAX   = 14'b00000000000100,
        ST_TFIT   = 14'b00000000001000,
        ST_TCOPY  = 14'b00000000010000,
        ST_GADD   = 14'b00000000100000,
        ST_GFIT   = 14'b00000001000000,
        ST_RESC   = 14'b00000010000000,
        ST_APPEND = 14'b00000100000000,
        ST_MMAX   = 14'b00001000000000,
        ST_MFIT   = 14'b00010000000000,
        ST_MCOPY  = 14'b00100000000000,
        ST_OUT    = 14'b01000000000000,
        ST_GSCALE = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] short_mem [SHORT_DEPTH];
    logic [ENTRY_BITS-1:0] long_mem [LONG_DEPTH];

    logic [5:0]  short_len_reg, short_len_next;
    logic [7:0]  long_len_reg, long_len_next;
    logic [5:0]  shift_reg, shift_next;
    logic [4:0]  res_reg, res_next;
    logic        phase_reg, phase_next;
    logic [SUM_BITS-1:0] gsum_reg, gsum_next;
    logic [15:0] gcnt_reg, gcnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] rval_reg, rval_next;

    logic        mode_reg, which_reg;
    logic [7:0]  idx_reg;
    logic [31:0] sample_reg;

    // Walk counters, scratch and the registered memory read data.
    logic [8:0]  i_reg, i_next;
    logic [1:0]  ph_reg, ph_next;
    logic [SUM_BITS:0] top_reg, top_next;
    logic [5:0]  s_reg, s_next;
    logic [ENTRY_BITS-1:0] a_reg, a_next;
    logic [31:0] srd_reg;
    logic [ENTRY_BITS-1:0] lrd_reg;

    logic        sw_en, lw_en;
    logic [SA-1:0] sw_addr, sr_addr;
    logic [LA-1:0] lw_addr, lr_addr;
    logic [31:0] sw_data;
    logic [ENTRY_BITS-1:0] lw_data;

    shr_req_t req;
    logic [SUM_BITS:0] shy;
    logic shfits;

    logic state_from_xfer;
    logic xfer_flag_reg;

    dasl_shifter #(.ENTRY_BITS(ENTRY_BITS)) u_shr (.req(req), .y(shy), .fits(shfits));

    always_ff @(posedge aclk) begin
        if (sw_en) short_mem[sw_addr] <= sw_data;
        srd_reg <= short_mem[sr_addr];
    end

    always_ff @(posedge aclk) begin
        if (lw_en) long_mem[lw_addr] <= lw_data;
        lrd_reg <= long_mem[lr_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg   <= s_mode;
            which_reg  <= s_which_log;
            idx_reg    <= s_entry_index;
            sample_reg <= s_sample;
        end
        i_reg    <= i_next;
        ph_reg   <= ph_next;
        top_reg  <= top_next;
        s_reg    <= s_next;
        a_reg    <= a_next;
        rval_reg <= rval_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            short_len_reg <= '0;
            long_len_reg  <= '0;
            shift_reg     <= '0;
            res_reg       <= 5'd1;
            phase_reg     <= 1'b0;
            gsum_reg      <= '0;
            gcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            short_len_reg <= short_len_next;
            long_len_reg  <= long_len_next;
            shift_reg     <= shift_next;
            res_reg       <= res_next;
            phase_reg     <= phase_next;
            gsum_reg      <= gsum_next;
            gcnt_reg      <= gcnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    function automatic logic [5:0] sat_add(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] t;
        begin
            t = {1'b0, a} + {1'b0, b};
            sat_add = (t > 7'(SHIFT_MAX)) ? 6'(SHIFT_MAX) : t[5:0];
        end
    endfunction

    always_comb begin
        logic [SUM_BITS:0] pair;
        logic [15:0] gc;
        logic [SUM_BITS:0] flush;
        state_next     = state_reg;
        short_len_next = short_len_reg;
        long_len_next  = long_len_reg;
        shift_next     = shift_reg;
        res_next       = res_reg;
        phase_next     = phase_reg;
        gsum_next      = gsum_reg;
        gcnt_next      = gcnt_reg;
        m_valid_next   = m_valid_reg;
        rval_next      = rval_reg;
        i_next  = i_reg;
        ph_next = ph_reg;
        top_next = top_reg;
        s_next  = s_reg;
        a_next  = a_reg;
        sw_en = 1'b0; lw_en = 1'b0;
        sw_addr = SA'(short_len_reg);
        sw_data = sample_reg;
        sr_addr = SA'(i_reg);
        lr_addr = LA'(i_reg);
        lw_addr = LA'(i_reg);
        lw_data = '0;
        req.x = '0;
        req.s = s_reg;
        pair = {{(SUM_BITS+1-ENTRY_BITS){1'b0}}, lrd_reg} + {{(SUM_BITS+1-ENTRY_BITS){1'b0}}, a_reg};
        gc = '0;
        flush = '0;

        case (state_reg)
            ST_IDLE: begin
                i_next = '0; ph_next = '0;
                if (s_valid) begin
                    rval_next = '0;
                    if (s_mode == MODE_READ) begin
                        i_next = {1'b0, s_entry_index};
                        state_next = ST_READ;
                    end else if (phase_reg) begin
                        state_next = ST_GADD;
                    end else if (short_len_reg < 6'(SHORT_DEPTH)) begin
                        state_next = ST_APPEND;
                    end else begin
                        top_next = '0;
                        state_next = ST_TMAX;
                    end
                end
            end
            ST_READ: begin
                // The first phase addresses the memory, the next takes the registered data.
                if (ph_reg == 2'd0) begin
                    ph_next = 2'd1;
                end else begin
                    if (which_reg == LOG_SHORT) begin
                        if ({1'b0, idx_reg} < 9'(short_len_reg) && {1'b0, idx_reg} < 9'(SHORT_DEPTH))
                            rval_next = srd_reg;
                    end else begin
                        if (idx_reg < long_len_reg && {1'b0, idx_reg} < 9'(LONG_DEPTH))
                            rval_next = 32'(lrd_reg);
                    end
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_APPEND: begin
                if (!phase_reg) begin
                    sw_en = 1'b1;
                    short_len_next = short_len_reg + 6'd1;
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    // Finished group: append, clear and merge if full.
                    if (long_len_reg < 8'(LONG_DEPTH)) begin
                        lw_en = 1'b1;
                        lw_addr = LA'(long_len_reg);
                        lw_data = gsum_reg[ENTRY_BITS-1:0];
                        long_len_next = long_len_reg + 8'd1;
                    end
                    gsum_next = '0;
                    gcnt_next = '0;
                    if ({1'b0, long_len_next} >= 9'(LONG_DEPTH)) begin
                        i_next = '0; ph_next = '0; top_next = '0;
                        state_next = ST_MMAX;
                    end else begin
                        m_valid_next = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_TMAX: begin
                // Pipelined scan: address i, data arrives the cycle after.
                if (ph_reg != 2'd0 && {1'b0, srd_reg} > top_reg[32:0])
                    top_next = {{(SUM_BITS-31){1'b0}}, srd_reg};
                ph_next = 2'd1;
                if (i_reg == 9'(SHORT_DEPTH)) begin
                    s_next = '0;
                    state_next = ST_TFIT;
                end else begin
                    i_next = i_reg + 9'd1;
                end
            end
            ST_TFIT: begin
                req.x = top_reg;
                if (shfits || s_reg == 6'(SHIFT_MAX)) begin
                    i_next = '0; ph_next = '0;
                    state_next = ST_TCOPY;
                end else begin
                    s_next = s_reg + 6'd1;
                end
            end
            ST_TCOPY: begin
                req.x = {{(SUM_BITS-31){1'b0}}, srd_reg};
                if (ph_reg == 2'd0) begin
                    ph_next = 2'd1;
                end else begin
                    lw_en = 1'b1;
                    lw_addr = LA'(i_reg);
                    lw_data = shy[ENTRY_BITS-1:0];
                    if (i_reg == 9'(NXFER - 1)) begin
                        long_len_next = 8'(NXFER);
                        shift_next = s_reg;
                        res_next = 5'd1;
                        phase_next = 1'b1;
                        gsum_next = '0;
                        gcnt_next = '0;
                        i_next = '0; ph_next = '0; top_next = '0;
                        if (NXFER >= LONG_DEPTH) begin
                            state_next = ST_MMAX;
                        end else begin
                            state_next = ST_GADD;
                        end
                    end else begin
                        i_next = i_reg + 9'd1;
                        ph_next = 2'd0;
                    end
                end
            end
            ST_GADD: begin
                gsum_next = gsum_reg + {{(SUM_BITS-32){1'b0}}, sample_reg};
                gc = gcnt_reg + 16'd1;
                gcnt_next = gc;
                flush = {{SUM_BITS{1'b0}}, 1'b1} << (res_reg - 5'd1);
                if ({{(SUM_BITS-15){1'b0}}, gc} != flush) begin
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_GSCALE;
                end
            end
            ST_GSCALE: begin
                req.x = {1'b0, gsum_reg};
                req.s = shift_reg;
                gsum_next = shy[SUM_BITS-1:0];
                if (shfits) begin
                    state_next = ST_APPEND;
                end else begin
                    s_next = 6'd1;
                    state_next = ST_GFIT;
                end
            end
            ST_GFIT: begin
                req.x = {1'b0, gsum_reg};
                if (shfits || s_reg == 6'(SHIFT_MAX)) begin
                    gsum_next = shy[SUM_BITS-1:0];
                    shift_next = sat_add(shift_reg, s_reg);
                    i_next = '0; ph_next = '0;
                    state_next = (long_len_reg == 8'd0) ? ST_APPEND : ST_RESC;
                end else begin
                    s_next = s_reg + 6'd1;
                end
            end
            ST_RESC: begin
                req.x = {{(SUM_BITS+1-ENTRY_BITS){1'b0}}, lrd_reg};
                if (ph_reg == 2'd0) begin
                    ph_next = 2'd1;
                end else begin
                    lw_en = 1'b1;
                    lw_data = shy[ENTRY_BITS-1:0];
                    ph_next = 2'd0;
                    if (i_reg == 9'(long_len_reg) - 9'd1 || i_reg == 9'(LONG_DEPTH - 1)) begin
                        state_next = ST_APPEND;
                    end else begin
                        i_next = i_reg + 9'd1;
                    end
                end
            end
            ST_MMAX: begin
                // Per pair: read even, read odd, compare the sum.
                lr_addr = LA'({i_reg[7:0], ph_reg[0]});
                case (ph_reg)
                    2'd0: ph_next = 2'd1;
                    2'd1: begin
                        a_next = lrd_reg;
                        ph_next = 2'd2;
                    end
                    default: begin
                        if (pair > top_next) top_next = pair;
                        ph_next = 2'd0;
                        if (i_reg == 9'(HALF - 1)) begin
                            i_next = '0; s_next = '0;
                            state_next = ST_MFIT;
                        end else begin
                            i_next = i_reg + 9'd1;
                        end
                    end
                endcase
            end
            ST_MFIT: begin
                req.x = top_reg;
                if (shfits || s_reg == 6'(SHIFT_MAX)) begin
                    i_next = '0; ph_next = '0;
                    state_next = ST_MCOPY;
                end else begin
                    s_next = s_reg + 6'd1;
                end
            end
            ST_MCOPY: begin
                lr_addr = LA'({i_reg[7:0], ph_reg[0]});
                req.x = pair;
                case (ph_reg)
                    2'd0: ph_next = 2'd1;
                    2'd1: begin
                        a_next = lrd_reg;
                        ph_next = 2'd2;
                    end
                    default: begin
                        lw_en = 1'b1;
                        lw_addr = LA'(i_reg);
                        lw_data = shy[ENTRY_BITS-1:0];
                        ph_next = 2'd0;
                        if (i_reg == 9'(HALF - 1)) begin
                            shift_next = sat_add(shift_reg, s_reg);
                            if (res_reg < 5'(RES_MAX)) res_next = res_reg + 5'd1;
                            long_len_next = 8'(HALF);
                            // A merge right after transfer still owes the sample.
                            state_next = (mode_reg == MODE_ADD && gcnt_reg == 16'd0
                                          && gsum_reg == '0 && state_from_xfer)
                                         ? ST_GADD : ST_OUT;
                            m_valid_next = (state_next == ST_OUT);
                        end else begin
                            i_next = i_reg + 9'd1;
                        end
                    end
                endcase
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Marks a merge that came straight from the transfer, before the sample was added.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xfer_flag_reg <= 1'b0;
        end else if (state_reg == ST_TCOPY && state_next == ST_MMAX) begin
            xfer_flag_reg <= 1'b1;
        end else if (state_reg == ST_IDLE) begin
            xfer_flag_reg <= 1'b0;
        end
    end
    assign state_from_xfer = xfer_flag_reg;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_read_value  = rval_reg;
    assign m_short_count = short_len_reg;
    assign m_long_count  = long_len_reg;
    assign m_scale_shift = shift_reg;
    assign m_resolution  = res_reg;
    assign m_long_phase  = phase_reg;

    a_ready_valid_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");
    a_phase_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(phase_reg) |-> phase_reg)
        else $error("long phase was left");
    a_res_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_reg >= 5'd1 && res_reg <= 5'(RES_MAX))
        else $error("resolution out of range");
    a_long_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> long_len_reg < 8'(LONG_DEPTH))
        else $error("long store left full");
endmodule
